// File: rtl/utv_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTC timestamp validator package
// Shared types, status codes, string layout constants and the month table.
// -----------------------------------------------------------------------------
package utv_pkg;

  // Characters at or beyond this index mark the string as malformed.
  localparam int unsigned MaxLength = 64;

  localparam int unsigned PosW   = 7;
  localparam int unsigned YearW  = 14;
  localparam int unsigned FieldW = 7;
  localparam int unsigned StatW  = 3;

  localparam int unsigned OutDataW = 56;

  // String layout: YYYY-MM-DDTHH:MM:SS[.f+]Z
  localparam logic [PosW-1:0] PosFracDot  = 7'd19;
  localparam logic [PosW-1:0] PosShortFrac = 7'd20;  // index of a last char giving length 21
  localparam logic [PosW-1:0] PosSatMax   = 7'd127;

  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChTee    = 8'h54;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZulu   = 8'h5A;

  localparam logic [FieldW-1:0] MaxMonth  = 7'd12;
  localparam logic [FieldW-1:0] MaxHour   = 7'd23;
  localparam logic [FieldW-1:0] MaxMinSec = 7'd59;
  localparam logic [FieldW-1:0] LeapFeb   = 7'd29;
  localparam logic [FieldW-1:0] MonthFeb  = 7'd2;

  typedef enum logic [StatW-1:0] {
    ST_VALID = 3'd0,
    ST_SHAPE = 3'd1,
    ST_DIGIT = 3'd2,
    ST_RANGE = 3'd3,
    ST_DAY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5,
    FLD_SEP    = 3'd6
  } field_e;

  // Per-string scan state handed from the character scanner to the checker.
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic              shape_bad;
    logic              digit_bad;
    logic              lo_zero;     // last two year digits are both zero
    logic [1:0]        cent_mod4;   // first two year digits, modulo 4
  } scan_t;

  // Field that owns a character index below the fraction dot.
  function automatic field_e field_of(logic [PosW-1:0] idx);
    field_e f;
    case (idx)
      7'd0, 7'd1, 7'd2, 7'd3: f = FLD_YEAR;
      7'd5, 7'd6:             f = FLD_MONTH;
      7'd8, 7'd9:             f = FLD_DAY;
      7'd11, 7'd12:           f = FLD_HOUR;
      7'd14, 7'd15:           f = FLD_MINUTE;
      7'd17, 7'd18:           f = FLD_SECOND;
      default:                f = FLD_SEP;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] separator_at(logic [PosW-1:0] idx);
    logic [7:0] ch;
    case (idx)
      7'd10:        ch = ChTee;
      7'd13, 7'd16: ch = ChColon;
      default:      ch = ChDash;
    endcase
    return ch;
  endfunction

  // Common-year month length; months outside 1..12 never reach this check.
  function automatic logic [FieldW-1:0] month_days(logic [FieldW-1:0] month);
    logic [FieldW-1:0] days;
    case (month)
      7'd2:                      days = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   days = 7'd30;
      default:                   days = 7'd31;
    endcase
    return days;
  endfunction

endpackage

// File: rtl/utc_timestamp_validator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTC timestamp validator
// Checks YYYY-MM-DDTHH:MM:SS[.digits]Z one character per beat and reports a
// status and the parsed fields on the final character of each string.
// -----------------------------------------------------------------------------
// The result beat is presented in the cycle after the final character.
// Throughput: one character per cycle; the output register drains in the same
// cycle it reloads, so input is only held while a result waits unaccepted.
// Reset clears the scan state and the output valid flag; no sweep is needed.
module utc_timestamp_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [2:0] status, [16:3] year, [23:17] month,
                                      // [30:24] day, [37:31] hour, [44:38] minute,
                                      // [51:45] second, [55:52] zero
);
  import utv_pkg::*;

  logic                  in_beat;
  logic                  final_beat;
  scan_t                 scan;
  status_e               status;
  logic                  shape_err;
  logic                  range_err;
  logic                  leap;
  logic [FieldW-1:0]     max_day;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign final_beat    = in_beat && s_axis_tlast;

  utv_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (in_beat),
    .char_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .scan_o (scan)
  );

  // A final character before index 19 means a length below 20, which is a shape
  // error on its own, so the field checks only need the registered scan state.
  assign shape_err = scan.shape_bad || (scan.pos < PosFracDot) ||
                     (scan.pos == PosShortFrac) || (scan.pos >= PosW'(MaxLength)) ||
                     (s_axis_tdata != ChZulu);

  assign range_err = (scan.year == '0) || (scan.month == '0) || (scan.month > MaxMonth) ||
                     (scan.day == '0) || (scan.hour > MaxHour) ||
                     (scan.minute > MaxMinSec) || (scan.second > MaxMinSec);

  // Divisible by 4, and either not a whole century or a century divisible by 4.
  assign leap    = (scan.year[1:0] == 2'd0) && (!scan.lo_zero || scan.cent_mod4 == 2'd0);
  assign max_day = (scan.month == MonthFeb && leap) ? LeapFeb : month_days(scan.month);

  always_comb begin
    if (shape_err) begin
      status = ST_SHAPE;
    end else if (scan.digit_bad) begin
      status = ST_DIGIT;
    end else if (range_err) begin
      status = ST_RANGE;
    end else if (scan.day > max_day) begin
      status = ST_DAY;
    end else begin
      status = ST_VALID;
    end
  end

  always_comb begin
    if (status == ST_SHAPE || status == ST_DIGIT) begin
      out_data_d = {{(OutDataW - StatW){1'b0}}, status};
    end else begin
      out_data_d = {4'd0, scan.second, scan.minute, scan.hour, scan.day, scan.month,
                    scan.year, status};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (final_beat) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (final_beat) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_beat |=> m_axis_tvalid)
    else $error("final beat produced no result");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(final_beat))
    else $error("result appeared without a final beat");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == ST_SHAPE || m_axis_tdata[2:0] == ST_DIGIT)
      |-> m_axis_tdata[55:3] == '0)
    else $error("fields not cleared on a shape or digit error");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !final_beat)
    else $error("pending result overwritten");

endmodule

// File: rtl/utv_scan.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTC timestamp validator character scanner
// Tracks the character index, accumulates the six decimal fields and keeps
// sticky shape and digit error flags for the string in progress.
// -----------------------------------------------------------------------------
module utv_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    char_i,
  input  logic          last_i,
  output utv_pkg::scan_t scan_o
);
  import utv_pkg::*;

  scan_t           scan_q, scan_d;
  logic [PosW-1:0] idx;
  logic            is_digit;
  logic [3:0]      digit;
  field_e          field;

  assign idx      = scan_q.pos;
  assign is_digit = (char_i >= ChDigit0) && (char_i <= ChDigit9);
  assign digit    = is_digit ? 4'(char_i - ChDigit0) : 4'd0;
  assign field    = field_of(idx);

  always_comb begin
    scan_d = scan_q;
    if (beat_i) begin
      if (last_i) begin
        // The string ends here: the checker samples scan_q this cycle.
        scan_d = '0;
      end else begin
        if (idx >= PosW'(MaxLength)) begin
          scan_d.shape_bad = 1'b1;
        end
        if (idx < PosFracDot) begin
          if (field == FLD_SEP) begin
            if (char_i != separator_at(idx)) begin
              scan_d.shape_bad = 1'b1;
            end
          end else if (!is_digit) begin
            scan_d.digit_bad = 1'b1;
          end else begin
            case (field)
              FLD_YEAR: begin
                scan_d.year = YearW'(scan_q.year * YearW'(10) + YearW'(digit));
                case (idx[1:0])
                  2'd0: scan_d.cent_mod4 = {digit[0], 1'b0};
                  2'd1: scan_d.cent_mod4 = scan_q.cent_mod4 + digit[1:0];
                  2'd2: scan_d.lo_zero = (digit == 4'd0);
                  default: scan_d.lo_zero = scan_q.lo_zero && (digit == 4'd0);
                endcase
              end
              FLD_MONTH:
                scan_d.month = FieldW'(scan_q.month * FieldW'(10) + FieldW'(digit));
              FLD_DAY:
                scan_d.day = FieldW'(scan_q.day * FieldW'(10) + FieldW'(digit));
              FLD_HOUR:
                scan_d.hour = FieldW'(scan_q.hour * FieldW'(10) + FieldW'(digit));
              FLD_MINUTE:
                scan_d.minute = FieldW'(scan_q.minute * FieldW'(10) + FieldW'(digit));
              default:
                scan_d.second = FieldW'(scan_q.second * FieldW'(10) + FieldW'(digit));
            endcase
          end
        end else if (idx == PosFracDot) begin
          if (char_i != ChDot) begin
            scan_d.shape_bad = 1'b1;
          end
        end else if (!is_digit) begin
          scan_d.shape_bad = 1'b1;
        end
        scan_d.pos = (idx < PosSatMax) ? idx + PosW'(1) : PosSatMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_i |=> scan_q.pos == '0 && !scan_q.shape_bad && !scan_q.digit_bad)
    else $error("scan state not cleared after the final beat");

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !beat_i |=> $stable(scan_q))
    else $error("scan state changed without an accepted beat");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && !last_i && idx == PosSatMax |=> scan_q.pos == PosSatMax)
    else $error("character index wrapped past saturation");

endmodule
